// File: rtl/core/kds_pkg.sv
// Shared types and codes for the keypad debounce scanner.
package kds_pkg;

    // Operation codes carried on the input beat
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_UPDATE = 2'd0;
    localparam t_opcode OP_FETCH  = 2'd1;
    localparam t_opcode OP_ADD    = 2'd2;

    // Per-key debounce state codes
    typedef logic [2:0] t_kstate;
    localparam t_kstate KS_REST      = 3'd0;
    localparam t_kstate KS_HELD      = 3'd1;
    localparam t_kstate KS_CONFIRMED = 3'd2;
    localparam t_kstate KS_PRESSED   = 3'd3;
    localparam t_kstate KS_ERROR     = 3'd4;
    localparam t_kstate KS_IDLE      = 3'd5;

    // Level and fault vectors cover the full sixteen-key map
    localparam int KEY_MAP_W = 16;
    localparam int KEY_SEL_W = 4;

    // One key's debounce record
    typedef struct packed {
        t_kstate     st;
        logic [31:0] start;
    } t_key_rec;

endpackage

// File: rtl/core/keypad_debounce_scanner_top.sv
// Keypad debounce scanner top level: key table, sequencer and result register.
// An add or an ignored opcode finishes on its first step; update and fetch
// visit the N registered keys in turn (fetch stops early at the first pressed
// key). One key is visited per cycle by the shared key update unit while the result
// slot is free; a new beat is taken only once the previous scan is done.
// Reset (synchronous, active low) empties the table, returns every key to rest.
module keypad_debounce_scanner_top #(
    parameter int MAX_KEYS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  kds_pkg::t_opcode i_opcode,
    input  logic [15:0]      i_key_levels,
    input  logic [15:0]      i_key_faults,
    input  logic [31:0]      i_now_ms,
    input  logic             i_update_first,
    input  logic [7:0]       i_new_key_code,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output logic [7:0]       o_pressed_code,
    output logic             o_add_ok
);
    import kds_pkg::*;

    localparam int IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CntW = $clog2(MAX_KEYS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_KEYS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic              r_state;
    logic [15:0]       r_debounce_ms;
    t_opcode           r_op;
    logic [15:0]       r_levels;
    logic [15:0]       r_faults;
    logic [31:0]       r_now;
    logic              r_upd;
    logic [7:0]        r_new_code;
    t_kstate           r_kstate [MAX_KEYS];
    logic [31:0]       r_kstart [MAX_KEYS];
    logic [7:0]        r_codes  [MAX_KEYS];
    logic [CntW-1:0]   r_idx;
    logic [CntW-1:0]   r_count;
    logic              r_out_valid;
    logic              r_found;
    logic [7:0]        r_pcode;
    logic              r_add_ok;

    logic [IdxW-1:0]   cur_idx;
    logic [IdxW-1:0]   add_idx;
    logic [KEY_SEL_W-1:0] key_sel;
    t_key_rec          cur_key;
    t_key_rec          n_key;
    logic              slot_free;
    logic              step;
    logic              in_range;
    logic              scan_op;
    logic              do_adv;
    t_kstate           after_st;
    logic              hit;
    logic              done;
    logic              add_go;

    // Select the key under visit
    assign cur_idx       = r_idx[IdxW-1:0];
    assign add_idx       = r_count[IdxW-1:0];
    assign key_sel       = KEY_SEL_W'(cur_idx);
    assign cur_key.st    = r_kstate[cur_idx];
    assign cur_key.start = r_kstart[cur_idx];

    kds_key_unit u_key_unit (
        .i_cur         (cur_key),
        .i_high        (r_levels[key_sel]),
        .i_fault       (r_faults[key_sel]),
        .i_now_ms      (r_now),
        .i_debounce_ms (r_debounce_ms),
        .o_next        (n_key)
    );

    // Sequencer decisions for this cycle
    assign slot_free = !r_out_valid || i_out_ready;
    assign step      = (r_state == S_RUN) && slot_free;
    assign in_range  = r_idx < r_count;
    assign scan_op   = (r_op == OP_UPDATE) || (r_op == OP_FETCH);
    assign do_adv    = (r_op == OP_UPDATE) || ((r_op == OP_FETCH) && r_upd);
    assign after_st  = do_adv ? n_key.st : cur_key.st;
    assign hit       = (r_op == OP_FETCH) && in_range && (after_st == KS_PRESSED);
    assign add_go    = (r_op == OP_ADD) && (r_count < CntMax);
    assign done      = !scan_op || !in_range || hit || (r_idx == r_count - CntW'(1));

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_pressed_code = r_pcode;
    assign o_add_ok       = r_add_ok;

    // Control state and key records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_debounce_ms <= 16'd20;
            r_idx         <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < MAX_KEYS; k++) begin
                r_kstate[k] <= KS_REST;
                r_kstart[k] <= 32'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_debounce_ms <= i_cfg_data;
            end
            // Raise the result when the scan finishes, drop it once taken
            if (step && done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_IDLE) && i_in_valid) begin
                r_idx   <= '0;
                r_state <= S_RUN;
            end else if (step) begin
                // Write back the visited key
                if (scan_op && in_range) begin
                    if (do_adv || hit) begin
                        r_kstate[cur_idx] <= hit ? KS_REST : n_key.st;
                    end
                    if (do_adv) begin
                        r_kstart[cur_idx] <= n_key.start;
                    end
                end
                // Register a new key in the next free slot
                if (add_go) begin
                    r_kstate[add_idx] <= KS_REST;
                    r_count           <= r_count + CntW'(1);
                end
                r_idx <= r_idx + CntW'(1);
                if (done) begin
                    r_state <= S_IDLE;
                end
            end
        end
    end

    // Payload: input beat, key codes, result fields
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op       <= i_opcode;
            r_levels   <= i_key_levels;
            r_faults   <= i_key_faults;
            r_now      <= i_now_ms;
            r_upd      <= i_update_first;
            r_new_code <= i_new_key_code;
        end
        if (step) begin
            if (add_go) begin
                r_codes[add_idx] <= r_new_code;
            end
            if (done) begin
                r_found  <= hit;
                r_pcode  <= hit ? r_codes[cur_idx] : 8'd0;
                r_add_ok <= add_go;
            end
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax)
        else $error("key count beyond table size");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_idx <= r_count))
        else $error("scan index ran past registered keys");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_add_ok))
        else $error("fetch and add results both set");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_pressed_code == 8'd0))
        else $error("pressed code set without a found key");

endmodule

// File: rtl/core/kds_key_unit.sv
// Shared key update unit: advances one key's debounce record per cycle.
module kds_key_unit (
    input  kds_pkg::t_key_rec i_cur,
    input  logic              i_high,
    input  logic              i_fault,
    input  logic [31:0]       i_now_ms,
    input  logic [15:0]       i_debounce_ms,
    output kds_pkg::t_key_rec o_next
);
    import kds_pkg::*;

    logic [31:0] elapsed;
    logic        expired;

    // Wrap-around elapsed time against the debounce window
    assign elapsed = i_now_ms - i_cur.start;
    assign expired = elapsed > {16'd0, i_debounce_ms};

    // Advance the debounce state
    always_comb begin
        o_next = i_cur;
        if (i_fault) begin
            o_next.st    = KS_ERROR;
            o_next.start = 32'd0;
        end else begin
            unique case (i_cur.st)
                KS_REST: begin
                    if (i_high) begin
                        o_next.st    = KS_HELD;
                        o_next.start = i_now_ms;
                    end
                end
                KS_HELD: begin
                    if (!i_high) begin
                        o_next.st    = KS_REST;
                        o_next.start = 32'd0;
                    end else if (expired) begin
                        o_next.st    = KS_CONFIRMED;
                        o_next.start = 32'd0;
                    end
                end
                KS_CONFIRMED: begin
                    if (!i_high) begin
                        o_next.st = KS_PRESSED;
                    end
                end
                KS_ERROR: begin
                    if (i_high) begin
                        o_next.st    = KS_HELD;
                        o_next.start = i_now_ms;
                    end else begin
                        o_next.st = KS_REST;
                    end
                end
                KS_PRESSED, KS_IDLE: begin
                    o_next = i_cur;
                end
                default: begin
                    o_next.st    = KS_ERROR;
                    o_next.start = 32'd0;
                end
            endcase
        end
    end

endmodule

// File: sim/keypad_debounce_scanner_top_tb.sv
// Self-checking testbench for the keypad debounce scanner: directed and random scans.
module keypad_debounce_scanner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kds_pkg::*;

    localparam int NUM_KEYS = 16;
    // Opcode three has no package name; the block must ignore it
    localparam t_opcode OP_IGNORED = 2'd3;

    typedef struct {
        t_opcode     op;
        logic [15:0] levels;
        logic [15:0] faults;
        logic [31:0] now_ms;
        logic        upd;
        logic [7:0]  new_code;
    } t_scan_beat;

    typedef struct {
        logic       found;
        logic [7:0] code;
        logic       add_ok;
    } t_scan_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    t_opcode     i_opcode       = OP_UPDATE;
    logic [15:0] i_key_levels   = '0;
    logic [15:0] i_key_faults   = '0;
    logic [31:0] i_now_ms       = '0;
    logic        i_update_first = 1'b0;
    logic [7:0]  i_new_key_code = '0;
    logic        i_cfg_we       = 1'b0;
    logic [15:0] i_cfg_data     = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_found;
    logic [7:0]  o_pressed_code;
    logic        o_add_ok;

    // Key table as the block should hold it
    t_kstate     key_st    [NUM_KEYS];
    logic [31:0] key_start [NUM_KEYS];
    logic [7:0]  key_codes [NUM_KEYS];
    logic [4:0]  key_total;
    logic [15:0] debounce_limit;

    t_scan_result pending_scan_results[$];
    int           errors      = 0;
    int           burst_left  = 0;
    int           hold_cycles = 0;

    // Simulated keypad for the random traffic
    logic [15:0]  pad_level = '0;
    logic [31:0]  pad_clock = '0;

    keypad_debounce_scanner_top #(
        .MAX_KEYS(NUM_KEYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_key_levels   (i_key_levels),
        .i_key_faults   (i_key_faults),
        .i_now_ms       (i_now_ms),
        .i_update_first (i_update_first),
        .i_new_key_code (i_new_key_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_pressed_code (o_pressed_code),
        .o_add_ok       (o_add_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance one key from its level, fault and the current time
    task automatic debounce_key(input int k, input t_scan_beat b);
        logic        high;
        logic [31:0] held_for;
        high     = b.levels[k];
        held_for = b.now_ms - key_start[k];
        if (b.faults[k]) begin
            key_start[k] = '0;
            key_st[k]    = KS_ERROR;
        end else begin
            case (key_st[k])
                KS_REST: begin
                    if (high) begin
                        key_start[k] = b.now_ms;
                        key_st[k]    = KS_HELD;
                    end
                end
                KS_HELD: begin
                    if (!high) begin
                        key_start[k] = '0;
                        key_st[k]    = KS_REST;
                    end else if (held_for > {16'd0, debounce_limit}) begin
                        key_start[k] = '0;
                        key_st[k]    = KS_CONFIRMED;
                    end
                end
                KS_CONFIRMED: begin
                    if (!high) key_st[k] = KS_PRESSED;
                end
                KS_ERROR: begin
                    if (high) begin
                        key_start[k] = b.now_ms;
                        key_st[k]    = KS_HELD;
                    end else begin
                        key_st[k] = KS_REST;
                    end
                end
                KS_PRESSED, KS_IDLE: ;
                default: begin
                    // unused codes behave like a fault
                    key_start[k] = '0;
                    key_st[k]    = KS_ERROR;
                end
            endcase
        end
    endtask

    // Apply one beat to the key table and work out the result it must give
    task automatic predict_scan_result(input t_scan_beat b, output t_scan_result r);
        int n;
        bit done;
        n    = (key_total > NUM_KEYS) ? NUM_KEYS : key_total;
        done = 1'b0;
        r    = '{found: 1'b0, code: 8'd0, add_ok: 1'b0};
        case (b.op)
            OP_UPDATE: begin
                for (int k = 0; k < n; k++) debounce_key(k, b);
            end
            OP_FETCH: begin
                for (int k = 0; k < n && !done; k++) begin
                    if (b.upd) debounce_key(k, b);
                    if (key_st[k] == KS_PRESSED) begin
                        key_st[k] = KS_REST;
                        r.found   = 1'b1;
                        r.code    = key_codes[k];
                        done      = 1'b1;
                    end
                end
            end
            OP_ADD: begin
                if (n < NUM_KEYS) begin
                    key_st[n]    = KS_REST;
                    key_codes[n] = b.new_code;
                    key_total    = 5'(n + 1);
                    r.add_ok     = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Mostly short idles, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender gaps, with occasional bursts of back-to-back beats
    function automatic int pick_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 2) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        return pick_idle();
    endfunction

    function automatic t_scan_beat scan_beat(input t_opcode op, input logic [15:0] lv,
                                             input logic [15:0] flt, input logic [31:0] t,
                                             input logic upd, input logic [7:0] c);
        scan_beat = '{op: op, levels: lv, faults: flt, now_ms: t, upd: upd, new_code: c};
    endfunction

    // Offer one beat, hold it until accepted, then record its expected result
    task automatic send_scan(input t_scan_beat b);
        int           gap;
        t_scan_result want;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= b.op;
        i_key_levels   <= b.levels;
        i_key_faults   <= b.faults;
        i_now_ms       <= b.now_ms;
        i_update_first <= b.upd;
        i_new_key_code <= b.new_code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_scan_result(b, want);
        pending_scan_results.push_back(want);
    endtask

    // Stop offering and wait until every result is back and the block is idle
    task automatic drain_scans();
        i_in_valid <= 1'b0;
        while (pending_scan_results.size() != 0) @(posedge i_clk);
        repeat (NUM_KEYS + 8) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [15:0] v);
        drain_scans();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        debounce_limit = v;
        @(posedge i_clk);
    endtask

    // Update and fetch on an empty table, plus the ignored opcode
    task automatic test_empty_table();
        send_scan(scan_beat(OP_UPDATE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        send_scan(scan_beat(OP_FETCH, 16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1, 8'h00));
        send_scan(scan_beat(OP_IGNORED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'hFFFF, 32'h8000_0000, 1'b0, 8'h5A));
    endtask

    task automatic test_key_registration();
        send_scan(scan_beat(OP_ADD, 16'h0000, 16'h0000, 32'd0, 1'b0, 8'h00));
        send_scan(scan_beat(OP_ADD, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1, 8'hFF));
        send_scan(scan_beat(OP_ADD, 16'h0000, 16'h0000, 32'd0, 1'b0, 8'hA5));
    endtask

    // Walk keys through hold, confirm, press, error and fetch, across the time wrap
    task automatic test_debounce_rules();
        logic [31:0] t0;
        t0 = 32'hFFFF_FFF0;
        send_scan(scan_beat(OP_UPDATE, 16'h0001, 16'h0000, t0, 1'b0, 8'h00));
        // exactly the limit is not enough
        send_scan(scan_beat(OP_UPDATE, 16'h0001, 16'h0000, t0 + 32'd20, 1'b0, 8'h00));
        send_scan(scan_beat(OP_UPDATE, 16'h0001, 16'h0000, t0 + 32'd21, 1'b0, 8'h00));
        // confirmed but not yet released: nothing to fetch
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'h0000, t0 + 32'd22, 1'b0, 8'h00));
        send_scan(scan_beat(OP_UPDATE, 16'h0000, 16'h0006, t0 + 32'd30, 1'b0, 8'h00));
        // error with level high restarts holding, with level low returns to rest
        send_scan(scan_beat(OP_UPDATE, 16'h0002, 16'h0000, t0 + 32'd30, 1'b0, 8'h00));
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'h0000, t0 + 32'd31, 1'b0, 8'h00));
        send_scan(scan_beat(OP_UPDATE, 16'h0006, 16'h0000, t0 + 32'd60, 1'b0, 8'h00));
        send_scan(scan_beat(OP_UPDATE, 16'h0006, 16'h0000, t0 + 32'd100, 1'b0, 8'h00));
        send_scan(scan_beat(OP_UPDATE, 16'h0000, 16'h0000, t0 + 32'd101, 1'b0, 8'h00));
        // two pressed keys: fetch stops at the first
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'h0000, t0 + 32'd102, 1'b0, 8'h00));
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'h0000, t0 + 32'd103, 1'b1, 8'h00));
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'h0000, t0 + 32'd104, 1'b1, 8'h00));
        // a key released during the fetch's own update is found by it
        send_scan(scan_beat(OP_UPDATE, 16'h0001, 16'h0000, t0 + 32'd200, 1'b0, 8'h00));
        send_scan(scan_beat(OP_UPDATE, 16'h0001, 16'h0000, t0 + 32'd300, 1'b0, 8'h00));
        send_scan(scan_beat(OP_FETCH, 16'h0000, 16'h0000, t0 + 32'd301, 1'b1, 8'h00));
        // fault and high on the same key: the fault wins
        send_scan(scan_beat(OP_UPDATE, 16'h0007, 16'h0004, t0 + 32'd400, 1'b0, 8'h00));
    endtask

    // Keypad-like traffic: slowly toggling levels, advancing time, sparse faults
    task automatic test_random_scans(input int count, input int add_pct);
        int          r;
        int          step_max;
        logic [15:0] lv;
        logic [15:0] flt;
        t_opcode     op;
        for (int i = 0; i < count; i++) begin
            step_max = int'(debounce_limit) / 3 + 2;
            for (int k = 0; k < NUM_KEYS; k++)
                if ($urandom_range(0, 5) == 0) pad_level[k] = ~pad_level[k];
            r = $urandom_range(0, 99);
            if (r < 2) pad_clock = $urandom();
            else if (r < 4) pad_clock = pad_clock - $urandom_range(0, step_max);
            else pad_clock = pad_clock + $urandom_range(0, step_max);
            lv = ($urandom_range(0, 99) < 5) ? 16'($urandom()) : pad_level;
            r  = $urandom_range(0, 99);
            if (r < 8) flt = 16'h0001 << $urandom_range(0, 15);
            else if (r < 11) flt = 16'($urandom());
            else flt = '0;
            r = $urandom_range(0, 99);
            if (r < add_pct) op = OP_ADD;
            else if (r == 99) op = OP_IGNORED;
            else if (r < 60) op = OP_UPDATE;
            else op = OP_FETCH;
            send_scan(scan_beat(op, lv, flt, pad_clock, 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255))));
        end
    endtask

    // Fill every slot, then try adds that must be refused
    task automatic test_table_full();
        while (key_total < NUM_KEYS)
            send_scan(scan_beat(OP_ADD, 16'($urandom()), 16'h0000, pad_clock, 1'b0,
                                8'($urandom_range(0, 255))));
        repeat (2)
            send_scan(scan_beat(OP_ADD, 16'($urandom()), 16'($urandom()), pad_clock, 1'b1,
                                8'($urandom_range(0, 255))));
    endtask

    // Hold the output off while beats keep coming, then pause until all are back
    task automatic test_output_backpressure();
        hold_cycles = 300;
        test_random_scans(40, 0);
        drain_scans();
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_scan_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scan_results.size() == 0) begin
                $display("%0t: result beat with none outstanding: found %0b code %0h add_ok %0b",
                         $time, o_found, o_pressed_code, o_add_ok);
                errors++;
            end else begin
                want = pending_scan_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, want.found, o_found);
                    errors++;
                end
                if (o_pressed_code !== want.code) begin
                    $display("%0t: pressed_code mismatch, expected %0h actual %0h",
                             $time, want.code, o_pressed_code);
                    errors++;
                end
                if (o_add_ok !== want.add_ok) begin
                    $display("%0t: add_ok mismatch, expected %0b actual %0b",
                             $time, want.add_ok, o_add_ok);
                    errors++;
                end
            end
        end
    end

    // Receiver: ready runs and random stalls, or a long hold when asked
    initial begin : result_sink
        int run;
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                i_out_ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
                repeat (run) @(posedge i_clk);
                stall = pick_idle();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : run_limit
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin : run_tests
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_st[k]    = KS_REST;
            key_start[k] = '0;
            key_codes[k] = '0;
        end
        key_total      = '0;
        debounce_limit = 16'd20;
        pad_clock      = $urandom();

        // hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_key_registration();
        test_debounce_rules();
        write_debounce(16'd0);
        test_random_scans(250, 3);
        write_debounce(16'hFFFF);
        test_random_scans(250, 3);
        test_table_full();
        test_output_backpressure();
        write_debounce(16'd20);
        test_random_scans(400, 2);
        write_debounce(16'($urandom_range(1, 2000)));
        test_random_scans(350, 2);
        write_debounce(16'd1);
        test_random_scans(350, 2);
        drain_scans();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/kds_pkg.sv
rtl/core/kds_key_unit.sv
rtl/core/keypad_debounce_scanner_top.sv
sim/keypad_debounce_scanner_top_tb.sv
